FILE: hw/rtl/kmd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_pkg
// Shared types and constants of the key matrix debouncer.
// ----------------------------------------------------------------------------
package kmd_pkg;

   localparam int COLUMNS   = 16;
   localparam int ROWS      = 8;
   localparam int KEY_SLOTS = 128;
   localparam int KEY_W     = $clog2(KEY_SLOTS);

   localparam int COUNT_W = 16;
   localparam int TIME_W  = 32;

   // wide enough for COLUMNS * row + column and for the scan code
   localparam int SUM_W = 10;

   // configuration register indexes
   localparam logic [1:0] CSR_DEBOUNCE_TIME = 2'd0;
   localparam logic [1:0] CSR_IDLE_LEVEL    = 2'd1;
   localparam logic [1:0] CSR_COUNT_LIMIT   = 2'd2;
   localparam logic [1:0] CSR_MAX_SCAN_CODE = 2'd3;

   typedef enum logic [1:0] {
      PHASE_OFF     = 2'd0,
      PHASE_PRESS   = 2'd1,
      PHASE_HOLD    = 2'd2,
      PHASE_RELEASE = 2'd3
   } phase_type;

   typedef struct packed {
      phase_type            phase;
      logic [COUNT_W-1:0]   active_count;
      logic [COUNT_W-1:0]   inactive_count;
      logic [TIME_W-1:0]    decision_time;
   } key_entry_type;

   localparam key_entry_type ENTRY_RESET = '{
      phase:          PHASE_OFF,
      active_count:   '0,
      inactive_count: '1,
      decision_time:  '0
   };

endpackage

`default_nettype wire

FILE: hw/rtl/kmd_key_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_key_store
// Per-key state memory with a registered read, valid bits that stand
// in for the reset contents, and forwarding of the last written entry.
// ----------------------------------------------------------------------------
module kmd_key_store
   import kmd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             rd_en,
   input  wire logic [KEY_W-1:0] rd_key,
   output key_entry_type         rd_entry,
   input  wire logic             wr_en,
   input  wire logic [KEY_W-1:0] wr_key,
   input  wire key_entry_type    wr_entry
);

   key_entry_type mem [KEY_SLOTS];

   key_entry_type        rdata_ff;
   logic [KEY_W-1:0]     rd_key_ff;
   logic [KEY_SLOTS-1:0] valid_ff;
   logic                 wb_valid_ff;
   logic [KEY_W-1:0]     wb_key_ff;
   key_entry_type        wb_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_key] <= wr_entry;
      end
      if (rd_en) begin
         rdata_ff  <= mem[rd_key];
         rd_key_ff <= rd_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         wb_valid_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff[wr_key] <= 1'b1;
         wb_valid_ff      <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wb_key_ff   <= wr_key;
         wb_entry_ff <= wr_entry;
      end
   end

   // a write in the same cycle as the read is missed by the memory
   always_comb begin
      priority if (wb_valid_ff && (wb_key_ff == rd_key_ff)) begin
         rd_entry = wb_entry_ff;
      end else if (!valid_ff[rd_key_ff]) begin
         rd_entry = ENTRY_RESET;
      end else begin
         rd_entry = rdata_ff;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/key_matrix_debouncer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// key_matrix_debouncer
// Per-key debounce and press/hold/release tracking for a scanned key matrix.
// ----------------------------------------------------------------------------
// Each input word carries one sampled key (column, row, sense level) and the
// current millisecond time; the block answers with the scan code, the new key
// state and a changed flag, or with nothing when the scan code is above
// max_scan_code. Words are taken one per clock unless the output stalls: a
// word reads the key's entry from the state memory when accepted, is evaluated
// in the next cycle and, when the evaluation stage advances, written back and
// loaded into the output register. Back-to-back samples of the same key are
// served by forwarding the last write. After reset all keys read as off with
// zero active count and a full inactive count; no clearing pass. The user must
// ensure configuration is written only while no word is in flight (not enforced).
// ----------------------------------------------------------------------------
module key_matrix_debouncer
   import kmd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [3:0] column, [6:4] row, [7] sense_level, [39:8] now_ms
   input  wire logic [39:0] req_tdata,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] scan_code, [9:8] key_state, [10] state_changed, [15:11] zero
   output logic [15:0]      rsp_tdata,

   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   // configuration
   logic [7:0]         debounce_time_ff;
   logic               idle_level_ff;
   logic [COUNT_W-1:0] count_limit_ff;
   logic [7:0]         max_scan_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_time_ff <= 8'd5;
         idle_level_ff    <= 1'b0;
         count_limit_ff   <= '1;
         max_scan_code_ff <= 8'd128;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEBOUNCE_TIME: debounce_time_ff <= csr_wdata[7:0];
            CSR_IDLE_LEVEL:    idle_level_ff    <= csr_wdata[0];
            CSR_COUNT_LIMIT:   count_limit_ff   <= csr_wdata[COUNT_W-1:0];
            CSR_MAX_SCAN_CODE: max_scan_code_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // input decode
   logic [3:0]        in_column;
   logic [2:0]        in_row;
   logic              in_level;
   logic [TIME_W-1:0] in_now;
   logic [SUM_W-1:0]  in_key_wide;
   logic [SUM_W-1:0]  in_code_wide;
   logic              in_report;
   logic              req_accept;

   assign in_column    = req_tdata[3:0];
   assign in_row       = req_tdata[6:4];
   assign in_level     = req_tdata[7];
   assign in_now       = req_tdata[39:8];
   assign in_key_wide  = SUM_W'(COLUMNS) * SUM_W'(in_row) + SUM_W'(in_column);
   assign in_code_wide = in_key_wide + SUM_W'(1);
   assign in_report    = (SUM_W'(in_column) < SUM_W'(COLUMNS))
                      && (SUM_W'(in_row) < SUM_W'(ROWS))
                      && (in_key_wide < SUM_W'(KEY_SLOTS))
                      && (in_code_wide <= SUM_W'(max_scan_code_ff));

   // evaluation stage
   logic              s1_valid_ff;
   logic [KEY_W-1:0]  s1_key_ff;
   logic [7:0]        s1_code_ff;
   logic              s1_active_ff;
   logic [TIME_W-1:0] s1_now_ff;
   logic              s1_advance;
   logic              rsp_valid_ff;
   logic [15:0]       rsp_data_ff;

   assign s1_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_accept && in_report;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_key_ff    <= in_key_wide[KEY_W-1:0];
         s1_code_ff   <= in_code_wide[7:0];
         s1_active_ff <= (in_level != idle_level_ff);
         s1_now_ff    <= in_now;
      end
   end

   key_entry_type cur_entry;
   key_entry_type new_entry;
   logic          wr_en;

   kmd_key_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_key   (in_key_wide[KEY_W-1:0]),
      .rd_entry (cur_entry),
      .wr_en    (wr_en),
      .wr_key   (s1_key_ff),
      .wr_entry (new_entry)
   );

   assign wr_en = s1_valid_ff && s1_advance;

   logic [COUNT_W-1:0] act_next;
   logic [COUNT_W-1:0] inact_next;
   logic [TIME_W-1:0]  elapsed;
   logic               late;
   logic               wins;
   logic               held;
   phase_type          phase_next;

   always_comb begin
      if (s1_active_ff) begin
         act_next   = (cur_entry.active_count < count_limit_ff)
                    ? cur_entry.active_count + COUNT_W'(1) : cur_entry.active_count;
         inact_next = cur_entry.inactive_count >> 1;
      end else begin
         inact_next = (cur_entry.inactive_count < count_limit_ff)
                    ? cur_entry.inactive_count + COUNT_W'(1) : cur_entry.inactive_count;
         act_next   = cur_entry.active_count >> 1;
      end

      elapsed = s1_now_ff - cur_entry.decision_time;
      late    = (elapsed >= TIME_W'(debounce_time_ff));
      wins    = (act_next > inact_next);
      held    = 1'b0;

      if ((cur_entry.phase == PHASE_PRESS) || (cur_entry.phase == PHASE_HOLD)) begin
         priority if (wins) begin
            phase_next = PHASE_HOLD;
         end else if (late) begin
            phase_next = PHASE_RELEASE;
         end else begin
            phase_next = cur_entry.phase;
            held       = 1'b1;
         end
      end else begin
         priority if (!wins) begin
            phase_next = PHASE_OFF;
         end else if (late) begin
            phase_next = PHASE_PRESS;
         end else begin
            phase_next = cur_entry.phase;
            held       = 1'b1;
         end
      end

      new_entry.phase          = phase_next;
      new_entry.active_count   = act_next;
      new_entry.inactive_count = inact_next;
      new_entry.decision_time  = held ? cur_entry.decision_time : s1_now_ff;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rsp_data_ff <= {5'd0, (phase_next != cur_entry.phase), phase_next, s1_code_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
